// ----- rtl/egdr_pkg.sv -----
// Shared types, constants and tables for the encoder/gyro dead reckoning block.
// No dependencies; imported by egdr_front, egdr_back and the top level.
package egdr_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POSITION_BITS_DEF = 40;

    // Angles in 2^-16 degree
    localparam logic [24:0] FULL_TURN    = 25'd23592960;
    localparam logic [22:0] QUARTER_TURN = 23'd5898240;

    // Residual angle to radians: pi_q30 / (2 * quarter) = (45 * PI_HI + PI_LO) / (45 * 2^18)
    localparam logic [26:0] PI_HI        = 27'd74961320;
    localparam logic [4:0]  PI_LO        = 5'd26;

    // Reciprocals for constant division, floor(2^32 / n)
    localparam logic [26:0] RECIP_45     = 27'd95443717;
    localparam logic [26:0] RECIP_50     = 27'd85899345;
    localparam logic [5:0]  DIV_45       = 6'd45;
    localparam logic [5:0]  DIV_50       = 6'd50;

    localparam logic [32:0] CORDIC_START = 33'd652032874;

    // Register indexes on the configuration port
    localparam logic REG_MM_PER_COUNT = 1'b0;
    localparam logic REG_CAL_SCALE    = 1'b1;

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] count;
        logic signed [21:0] yaw;
    } item_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/encoder_gyro_dead_reckoning_top.sv -----
// Top level of the encoder/gyro dead reckoning block: configuration registers,
// input queue (egdr_front) and sequencer (egdr_back). Depends on egdr_pkg.
//
//  channel   direction  handshake          payload
//  in        to block   in_valid/in_stall  operation, encoder_count, gyro_rate
//  out       from block out_valid/out_stall pos_x, pos_y, heading, range_from_origin
//  config    to block   APB psel/penable   mm_per_count @0x0, calibration_scale @0x4
//
// A tick's run time is dominated by the CORDIC iterations and the one-bit-per-cycle
// range square root. A clear-origin item goes straight to the output step.
// Items are worked on one at a time. The two-entry queue accepts until full,
// also while the sequencer runs or the output stalls.
// Reset clears position, heading, previous count and sets both registers to 1.0.
module encoder_gyro_dead_reckoning_top #(
    parameter int CORDIC_STEPS  = egdr_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_BITS = egdr_pkg::POSITION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic signed [15:0]  encoder_count,
    input  logic signed [21:0]  gyro_rate,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [39:0]  pos_x,
    output logic signed [39:0]  pos_y,
    output logic [24:0]         heading,
    output logic [39:0]         range_from_origin,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import egdr_pkg::*;

    logic [19:0] mpc_reg, mpc_next;
    logic [15:0] cal_reg, cal_next;
    logic        wr_en;
    item_t       q_item;
    logic        q_valid;
    logic        q_take;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        mpc_next = mpc_reg;
        cal_next = cal_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_MM_PER_COUNT: mpc_next = pwdata[19:0];
                REG_CAL_SCALE:    cal_next = pwdata[15:0];
            endcase
        end
        unique case (paddr[2])
            REG_MM_PER_COUNT: prdata = {12'd0, mpc_reg};
            REG_CAL_SCALE:    prdata = {16'd0, cal_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpc_reg <= 20'd16384;
            cal_reg <= 16'd16384;
        end
        else
        begin
            mpc_reg <= mpc_next;
            cal_reg <= cal_next;
        end
    end

    egdr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .encoder_count (encoder_count),
        .gyro_rate     (gyro_rate),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_take        (q_take)
    );

    egdr_back #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_item            (q_item),
        .q_valid           (q_valid),
        .q_take            (q_take),
        .mm_per_count      (mpc_reg),
        .calibration_scale (cal_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .heading           (heading),
        .range_from_origin (range_from_origin)
    );

endmodule

// ----- rtl/egdr_front.sv -----
// Input side: accepts tick and clear items and holds them in a two-entry queue.
// Depends on egdr_pkg (item_t).
module egdr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic signed [15:0]  encoder_count,
    input  logic signed [21:0]  gyro_rate,
    output egdr_pkg::item_t     q_item,
    output logic                q_valid,
    input  logic                q_take
);
    import egdr_pkg::*;

    item_t       q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_take && q_valid;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].op    <= operation;
            q_mem[wr_ptr_reg].count <= encoder_count;
            q_mem[wr_ptr_reg].yaw   <= gyro_rate;
        end
    end

endmodule

// ----- rtl/egdr_back.sv -----
// Sequencer that carries out one item: distance, heading, CORDIC, position update
// and bit-serial range square root, with an output register. Depends on egdr_pkg.
module egdr_back #(
    parameter int CORDIC_STEPS  = egdr_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_BITS = egdr_pkg::POSITION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  egdr_pkg::item_t     q_item,
    input  logic                q_valid,
    output logic                q_take,
    input  logic [19:0]         mm_per_count,
    input  logic [15:0]         calibration_scale,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [39:0]  pos_x,
    output logic signed [39:0]  pos_y,
    output logic [24:0]         heading,
    output logic [39:0]         range_from_origin
);
    import egdr_pkg::*;

    localparam int PB    = POSITION_BITS;
    localparam int LW    = (PB + 1) / 2;
    localparam int NW    = 2 * PB + 2;
    localparam int SQ_IT = PB + 1;
    localparam int RW    = SQ_IT + 2;
    localparam int SW    = PB + 2;
    localparam int CNT_W = $clog2(SQ_IT + CORDIC_STEPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_HEAD = 4'd4;
    localparam logic [3:0] S_ANG1 = 4'd5;
    localparam logic [3:0] S_ANG2 = 4'd6;
    localparam logic [3:0] S_ANG3 = 4'd7;
    localparam logic [3:0] S_CORD = 4'd8;
    localparam logic [3:0] S_TRIG = 4'd9;
    localparam logic [3:0] S_AXIS = 4'd10;
    localparam logic [3:0] S_SQR  = 4'd11;
    localparam logic [3:0] S_SQRT = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    localparam logic signed [SW-1:0] POS_MAX = SW'((64'sd1 <<< (PB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] POS_MIN = SW'(-(64'sd1 <<< (PB - 1)));

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        step_reg, step_next;
    logic [15:0]             prev_reg, prev_next;
    logic [24:0]             heading_reg, heading_next;
    logic signed [PB-1:0]    x_reg, x_next;
    logic signed [PB-1:0]    y_reg, y_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [15:0]      count_reg, count_next;
    logic signed [21:0]      yaw_reg, yaw_next;
    logic [15:0]             dmag_reg, dmag_next;
    logic                    dneg_reg, dneg_next;
    logic                    yneg_reg, yneg_next;
    logic [27:0]             vdiv_reg, vdiv_next;
    logic [35:0]             prod_reg, prod_next;
    logic [22:0]             qy_reg, qy_next;
    logic [51:0]             prod2_reg, prod2_next;
    logic [21:0]             incmag_reg, incmag_next;
    logic [37:0]             dmm_reg, dmm_next;
    logic [1:0]              quad_reg, quad_next;
    logic [48:0]             areg_reg, areg_next;
    logic [27:0]             breg_reg, breg_next;
    logic [22:0]             bq_reg, bq_next;
    logic signed [32:0]      cx_reg, cx_next;
    logic signed [32:0]      cy_reg, cy_next;
    logic signed [32:0]      cz_reg, cz_next;
    logic [25:0]             cmag_reg, cmag_next;
    logic                    cneg_reg, cneg_next;
    logic [25:0]             smag_reg, smag_next;
    logic                    sneg_reg, sneg_next;
    logic [63:0]             acc_reg, acc_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [RW-1:0]           rem_reg, rem_next;
    logic [SQ_IT-1:0]        root_reg, root_next;
    logic signed [39:0]      px_reg, px_next;
    logic signed [39:0]      py_reg, py_next;
    logic [24:0]             hd_reg, hd_next;
    logic [39:0]             rg_reg, rg_next;

    // Combinational helpers
    logic signed [17:0]      diff;
    logic [21:0]             ymag;
    logic [54:0]             yprod;
    logic [27:0]             yrem;
    logic signed [26:0]      hsum;
    logic [22:0]             resid;
    logic [54:0]             bprod;
    logic [27:0]             brem;
    logic [22:0]             bdiv;
    logic signed [32:0]      xs, ys;
    logic [29:0]             atan_v;
    logic signed [32:0]      cf, sf, xf, yf;
    logic [18:0]             dpart;
    logic [25:0]             tmag;
    logic [44:0]             pp;
    logic [63:0]             full;
    logic [31:0]             smag_step;
    logic signed [SW-1:0]    step_s;
    logic signed [SW-1:0]    psum;
    logic signed [PB-1:0]    psat;
    logic signed [PB-1:0]    axis;
    logic [PB-1:0]           amag;
    logic [LW-1:0]           ma, mb;
    logic [2*LW-1:0]         sp;
    logic [NW-1:0]           sp_sh;
    logic [RW-1:0]           remsh, trial;
    logic signed [48:0]      xe, ye;

    assign q_take = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        prev_next      = prev_reg;
        heading_next   = heading_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && out_stall;
        count_next     = count_reg;
        yaw_next       = yaw_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        yneg_next      = yneg_reg;
        vdiv_next      = vdiv_reg;
        prod_next      = prod_reg;
        qy_next        = qy_reg;
        prod2_next     = prod2_reg;
        incmag_next    = incmag_reg;
        dmm_next       = dmm_reg;
        quad_next      = quad_reg;
        areg_next      = areg_reg;
        breg_next      = breg_reg;
        bq_next        = bq_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        cmag_next      = cmag_reg;
        cneg_next      = cneg_reg;
        smag_next      = smag_reg;
        sneg_next      = sneg_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hd_next        = hd_reg;
        rg_next        = rg_reg;

        diff      = 18'(count_reg) - 18'($signed(prev_reg));
        ymag      = yaw_reg[21] ? 22'(-yaw_reg) : 22'(yaw_reg);
        yprod     = 55'(vdiv_reg) * 55'(RECIP_50);
        yrem      = vdiv_reg - 28'(qy_reg * 28'(DIV_50));
        hsum      = $signed({2'b00, heading_reg})
                  + (yneg_reg ? -$signed({5'd0, incmag_reg}) : $signed({5'd0, incmag_reg}));
        resid     = 23'd0;
        bprod     = 55'(breg_reg) * 55'(RECIP_45);
        brem      = breg_reg - 28'(bq_reg * 28'(DIV_45));
        bdiv      = bq_reg + 23'(brem >= 28'(DIV_45));
        xs        = cx_reg >>> step_reg;
        ys        = cy_reg >>> step_reg;
        atan_v    = atan_q30(step_reg[4:0]);
        xf        = cx_reg >>> 6;
        yf        = cy_reg >>> 6;
        cf        = xf;
        sf        = yf;
        dpart     = step_reg[0] ? dmm_reg[37:19] : dmm_reg[18:0];
        tmag      = step_reg[1] ? smag_reg : cmag_reg;
        pp        = 45'(dpart) * 45'(tmag);
        full      = acc_reg + (64'(pp) << 19);
        smag_step = 32'((full + 64'h8000_0000) >> 32);
        step_s    = (dneg_reg ^ (step_reg[1] ? sneg_reg : cneg_reg))
                  ? -$signed(SW'(smag_step)) : $signed(SW'(smag_step));
        axis      = step_reg[1] ? y_reg : x_reg;
        psum      = SW'(axis) + step_s;
        if (psum > POS_MAX)
            psat = PB'(POS_MAX);
        else if (psum < POS_MIN)
            psat = PB'(POS_MIN);
        else
            psat = PB'(psum);
        amag      = (step_reg >= CNT_W'(3)) ? (y_reg[PB-1] ? PB'(-y_reg) : PB'(y_reg))
                                           : (x_reg[PB-1] ? PB'(-x_reg) : PB'(x_reg));
        ma        = LW'(amag >> LW);
        mb        = amag[LW-1:0];
        sp        = '0;
        sp_sh     = NW'(0);
        remsh     = {rem_reg[RW-3:0], n_reg[NW-1:NW-2]};
        trial     = {root_reg, 2'b01};
        xe        = 49'(x_reg);
        ye        = 49'(y_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    count_next = q_item.count;
                    yaw_next   = q_item.yaw;
                    if (q_item.op == OP_CLEAR)
                    begin
                        prev_next    = 16'd0;
                        heading_next = 25'd0;
                        x_next       = '0;
                        y_next       = '0;
                        root_next    = '0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                // Fold the counter difference back into one 16-bit turn
                if (diff > 18'sd32768)
                    diff = diff - 18'sd65536;
                else if (diff < -18'sd32768)
                    diff = diff + 18'sd65536;
                dneg_next  = diff[17];
                dmag_next  = diff[17] ? 16'(-diff) : 16'(diff);
                prev_next  = count_reg;
                yneg_next  = yaw_reg[21];
                vdiv_next  = {ymag, 6'd0} + 28'd25;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = 36'(dmag_reg) * 36'(mm_per_count);
                qy_next    = 23'(yprod >> 32);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod2_next  = 52'(prod_reg) * 52'(calibration_scale);
                incmag_next = 22'(qy_reg) + 22'(yrem >= 28'(DIV_50));
                state_next  = S_HEAD;
            end
            S_HEAD:
            begin
                dmm_next = 38'((prod2_reg + 52'd8192) >> 14);
                if (hsum >= $signed({2'b00, FULL_TURN}))
                    hsum = hsum - $signed({2'b00, FULL_TURN});
                else if (hsum < 27'sd0)
                    hsum = hsum + $signed({2'b00, FULL_TURN});
                heading_next = hsum[24:0];
                state_next   = S_ANG1;
            end
            S_ANG1:
            begin
                if (heading_reg >= 25'(3 * QUARTER_TURN))
                begin
                    quad_next = 2'd3;
                    resid     = 23'(heading_reg - 25'(3 * QUARTER_TURN));
                end
                else if (heading_reg >= 25'(2 * QUARTER_TURN))
                begin
                    quad_next = 2'd2;
                    resid     = 23'(heading_reg - 25'(2 * QUARTER_TURN));
                end
                else if (heading_reg >= 25'(QUARTER_TURN))
                begin
                    quad_next = 2'd1;
                    resid     = 23'(heading_reg - 25'(QUARTER_TURN));
                end
                else
                begin
                    quad_next = 2'd0;
                    resid     = heading_reg[22:0];
                end
                areg_next  = 49'(resid) * 49'(PI_HI);
                breg_next  = 28'(resid) * 28'(PI_LO) + 28'(QUARTER_TURN);
                state_next = S_ANG2;
            end
            S_ANG2:
            begin
                bq_next    = 23'(bprod >> 32);
                state_next = S_ANG3;
            end
            S_ANG3:
            begin
                cz_next    = 33'((areg_reg + 49'(bdiv)) >> 18);
                cx_next    = $signed(CORDIC_START);
                cy_next    = 33'sd0;
                step_next  = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                if (!cz_reg[32])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - $signed(33'(atan_v));
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + $signed(33'(atan_v));
                end
                if (step_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = S_TRIG;
                else
                    step_next = step_reg + CNT_W'(1);
            end
            S_TRIG:
            begin
                unique case (quad_reg)
                    2'd0:
                    begin
                        cf = xf;
                        sf = yf;
                    end
                    2'd1:
                    begin
                        cf = -yf;
                        sf = xf;
                    end
                    2'd2:
                    begin
                        cf = -xf;
                        sf = -yf;
                    end
                    2'd3:
                    begin
                        cf = yf;
                        sf = -xf;
                    end
                endcase
                cneg_next  = cf[32];
                cmag_next  = cf[32] ? 26'(-cf) : 26'(cf);
                sneg_next  = sf[32];
                smag_next  = sf[32] ? 26'(-sf) : 26'(sf);
                step_next  = '0;
                state_next = S_AXIS;
            end
            S_AXIS:
            begin
                // Even steps take the low half of the distance, odd steps finish the axis
                if (!step_reg[0])
                begin
                    acc_next = 64'(pp);
                end
                else if (!step_reg[1])
                begin
                    x_next = psat;
                end
                else
                begin
                    y_next = psat;
                end
                if (step_reg == CNT_W'(3))
                begin
                    step_next  = '0;
                    n_next     = '0;
                    state_next = S_SQR;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_SQR:
            begin
                priority case (step_reg)
                    CNT_W'(0), CNT_W'(3):
                    begin
                        sp    = (2*LW)'(ma) * (2*LW)'(ma);
                        sp_sh = NW'(sp) << (2 * LW);
                    end
                    CNT_W'(1), CNT_W'(4):
                    begin
                        sp    = (2*LW)'(ma) * (2*LW)'(mb);
                        sp_sh = NW'(sp) << (LW + 1);
                    end
                    default:
                    begin
                        sp    = (2*LW)'(mb) * (2*LW)'(mb);
                        sp_sh = NW'(sp);
                    end
                endcase
                n_next = n_reg + sp_sh;
                if (step_reg == CNT_W'(5))
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_SQRT:
            begin
                if (remsh >= trial)
                begin
                    rem_next  = remsh - trial;
                    root_next = {root_reg[SQ_IT-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = remsh;
                    root_next = {root_reg[SQ_IT-2:0], 1'b0};
                end
                n_next = n_reg << 2;
                if (step_reg == CNT_W'(SQ_IT - 1))
                    state_next = S_DONE;
                else
                    step_next = step_reg + CNT_W'(1);
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    if (xe > 49'sh7F_FFFF_FFFF)
                        px_next = 40'sh7F_FFFF_FFFF;
                    else if (xe < -49'sh80_0000_0000)
                        px_next = -40'sh80_0000_0000;
                    else
                        px_next = 40'(xe);
                    if (ye > 49'sh7F_FFFF_FFFF)
                        py_next = 40'sh7F_FFFF_FFFF;
                    else if (ye < -49'sh80_0000_0000)
                        py_next = -40'sh80_0000_0000;
                    else
                        py_next = 40'(ye);
                    hd_next = heading_reg;
                    if (64'(root_reg) > 64'hFF_FFFF_FFFF)
                        rg_next = 40'hFF_FFFF_FFFF;
                    else
                        rg_next = 40'(root_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            prev_reg      <= 16'd0;
            heading_reg   <= 25'd0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            prev_reg      <= prev_next;
            heading_reg   <= heading_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        yaw_reg    <= yaw_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        yneg_reg   <= yneg_next;
        vdiv_reg   <= vdiv_next;
        prod_reg   <= prod_next;
        qy_reg     <= qy_next;
        prod2_reg  <= prod2_next;
        incmag_reg <= incmag_next;
        dmm_reg    <= dmm_next;
        quad_reg   <= quad_next;
        areg_reg   <= areg_next;
        breg_reg   <= breg_next;
        bq_reg     <= bq_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        cmag_reg   <= cmag_next;
        cneg_reg   <= cneg_next;
        smag_reg   <= smag_next;
        sneg_reg   <= sneg_next;
        acc_reg    <= acc_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        hd_reg     <= hd_next;
        rg_reg     <= rg_next;
    end

    assign out_valid         = out_valid_reg;
    assign pos_x             = px_reg;
    assign pos_y             = py_reg;
    assign heading           = hd_reg;
    assign range_from_origin = rg_reg;

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < FULL_TURN)
        else $error("heading left the 0..360 degree range");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished item not moved to the output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result overwritten while stalled");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORD) |-> (step_reg < CNT_W'(CORDIC_STEPS)))
        else $error("CORDIC ran past its step count");

endmodule
